@@ src/mkfc_pkg.sv @@
// Shared types and constants for the memcomparable key field codec.
`timescale 1ns / 1ps

package mkfc_pkg;

   localparam int unsigned DATA_BYTES = 8;
   localparam int unsigned LEN_W      = 4;
   localparam int unsigned PIPE_STAGES = 4;

   localparam logic [LEN_W-1:0] MAX_FIELD_BYTES = 4'd8;

   localparam logic OP_ENCODE = 1'b0;
   localparam logic OP_DECODE = 1'b1;

   localparam logic [7:0] SIGN_MASK = 8'h80;
   localparam logic [7:0] BYTE_MASK = 8'hFF;
   localparam logic [7:0] NULL_MASK = 8'h01;

   typedef enum logic [2:0] {
      TC_VARLEN      = 3'd0,
      TC_BIG_ENDIAN  = 3'd1,
      TC_UNSIGNED_LE = 3'd2,
      TC_SIGNED_INT  = 3'd3,
      TC_FLOAT       = 3'd4
   } tc_type;

   typedef struct packed {
      logic             op;
      logic             sgn;
      logic             flt;
      logic             act;
      logic [LEN_W-1:0] len;
   } ctl_type;

endpackage

@@ src/memcomparable_key_field_codec_unit.sv @@
// Top level: four-stage memcomparable key column encoder and decoder.
`timescale 1ns / 1ps

// Takes one fixed-length key column per transaction and encodes it into
// byte-order-comparable form or decodes it back. The block is a four-stage
// pipeline: input capture with control decode, byte reversal for encode,
// sign or float transform, byte reversal for decode. A new transaction is
// accepted every cycle unless req_stall is high; rsp_valid comes from the
// last of the four register stages.
// Stall on the result side backs up through the stages, and empty stages
// are filled while the output is held.
module memcomparable_key_field_codec_unit
   import mkfc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_op,
   input  logic [2:0]  req_type_class,
   input  logic [3:0]  req_data_len,
   input  logic        req_nullable,
   input  logic [7:0]  req_null_byte,
   input  logic [63:0] req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_null_byte_out,
   output logic [63:0] rsp_data_out
);

   function automatic logic [63:0] rev_bytes(input logic [63:0] d, input logic [LEN_W-1:0] n);
      logic [63:0] r;
      logic [2:0]  idx;
      r   = d;
      idx = '0;
      for (int i = 0; i < DATA_BYTES; i++) begin
         if (LEN_W'(i) < n) begin
            idx = 3'(n - 4'd1 - LEN_W'(i));
            r[i*8 +: 8] = d[{idx, 3'b000} +: 8];
         end
      end
      return r;
   endfunction

   logic adv1, adv2, adv3, adv4;

   logic        s1_vld_ff, s1_vld_in, s2_vld_ff, s2_vld_in, s3_vld_ff, s3_vld_in;
   logic        rsp_valid_ff, rsp_valid_in;
   ctl_type     s1_ctl_ff, s1_ctl_in, s2_ctl_ff, s3_ctl_ff;
   logic [7:0]  s1_nb_ff, s1_nb_in, s2_nb_ff, s3_nb_ff, rsp_nb_ff;
   logic [63:0] s1_data_ff, s2_data_ff, s2_data_in, s3_data_ff, s3_data_in;
   logic [63:0] rsp_data_ff, rsp_data_in;

   logic [LEN_W-1:0] len_sat;
   logic             fixed, nb_flip, not_null;
   logic [7:0]       native_nb;
   logic [63:0]      len_mask;
   logic             inv_all;

   assign adv4      = !rsp_valid_ff || !rsp_stall;
   assign adv3      = !s3_vld_ff || adv4;
   assign adv2      = !s2_vld_ff || adv3;
   assign adv1      = !s1_vld_ff || adv2;
   assign req_stall = !adv1;

   always_comb begin
      len_sat = (req_data_len > MAX_FIELD_BYTES) ? MAX_FIELD_BYTES : req_data_len;
      fixed   = (req_type_class == TC_BIG_ENDIAN) || (req_type_class == TC_UNSIGNED_LE) ||
                (req_type_class == TC_SIGNED_INT) || (req_type_class == TC_FLOAT);
      nb_flip = req_nullable && fixed;
      s1_nb_in  = req_null_byte ^ (nb_flip ? NULL_MASK : 8'h00);
      native_nb = (req_op == OP_DECODE) ? s1_nb_in : req_null_byte;
      not_null  = !req_nullable || (native_nb == 8'h00);
      s1_ctl_in.op  = req_op;
      s1_ctl_in.sgn = req_type_class == TC_SIGNED_INT;
      s1_ctl_in.flt = req_type_class == TC_FLOAT;
      s1_ctl_in.act = fixed && (req_type_class != TC_BIG_ENDIAN) &&
                      (len_sat != '0) && not_null;
      s1_ctl_in.len = len_sat;
   end

   // encode reverses before the transform
   always_comb begin
      s2_data_in = s1_data_ff;
      if (s1_ctl_ff.act && (s1_ctl_ff.op == OP_ENCODE)) begin
         s2_data_in = rev_bytes(s1_data_ff, s1_ctl_ff.len);
      end
   end

   always_comb begin
      for (int i = 0; i < DATA_BYTES; i++) begin
         len_mask[i*8 +: 8] = (LEN_W'(i) < s2_ctl_ff.len) ? BYTE_MASK : 8'h00;
      end
      inv_all    = s2_data_ff[7] != s2_ctl_ff.op;
      s3_data_in = s2_data_ff;
      if (s2_ctl_ff.act) begin
         if (s2_ctl_ff.sgn) begin
            s3_data_in[7:0] = s2_data_ff[7:0] ^ SIGN_MASK;
         end else if (s2_ctl_ff.flt) begin
            if (inv_all) begin
               s3_data_in = s2_data_ff ^ len_mask;
            end else begin
               s3_data_in[7:0] = s2_data_ff[7:0] ^ SIGN_MASK;
            end
         end
      end
   end

   // decode reverses after the transform
   always_comb begin
      rsp_data_in = s3_data_ff;
      if (s3_ctl_ff.act && (s3_ctl_ff.op == OP_DECODE)) begin
         rsp_data_in = rev_bytes(s3_data_ff, s3_ctl_ff.len);
      end
   end

   always_comb begin
      s1_vld_in    = adv1 ? req_valid : s1_vld_ff;
      s2_vld_in    = adv2 ? s1_vld_ff : s2_vld_ff;
      s3_vld_in    = adv3 ? s2_vld_ff : s3_vld_ff;
      rsp_valid_in = adv4 ? s3_vld_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         s3_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_vld_ff    <= s1_vld_in;
         s2_vld_ff    <= s2_vld_in;
         s3_vld_ff    <= s3_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_ctl_ff  <= s1_ctl_in;
         s1_nb_ff   <= s1_nb_in;
         s1_data_ff <= req_data;
      end
      if (adv2) begin
         s2_ctl_ff  <= s1_ctl_ff;
         s2_nb_ff   <= s1_nb_ff;
         s2_data_ff <= s2_data_in;
      end
      if (adv3) begin
         s3_ctl_ff  <= s2_ctl_ff;
         s3_nb_ff   <= s2_nb_ff;
         s3_data_ff <= s3_data_in;
      end
      if (adv4) begin
         rsp_nb_ff   <= s3_nb_ff;
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_null_byte_out = rsp_nb_ff;
   assign rsp_data_out      = rsp_data_ff;

endmodule

@@ src/mkfc_checker.sv @@
// Port-level assertions for the key field codec, bound to the top level.
`timescale 1ns / 1ps

module mkfc_checker
   import mkfc_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [7:0]  rsp_null_byte_out,
   input logic [63:0] rsp_data_out
);

   localparam int unsigned CNT_W = $clog2(PIPE_STAGES + 1);

   logic             req_acc, rsp_acc;
   logic [CNT_W-1:0] inflight_ff, inflight_in;

   assign req_acc = req_valid && !req_stall;
   assign rsp_acc = rsp_valid && !rsp_stall;

   always_comb begin
      inflight_in = inflight_ff + CNT_W'(req_acc) - CNT_W'(rsp_acc);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_in;
      end
   end

   a_reset_clears: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

   a_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data_out) &&
                                 $stable(rsp_null_byte_out))
      else $error("stalled result changed");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_acc |-> inflight_ff != '0)
      else $error("result without an accepted transaction");

   a_depth: assert property (@(posedge clock) disable iff (reset)
      inflight_ff <= CNT_W'(PIPE_STAGES))
      else $error("more transactions in flight than stages");

   a_flow: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("input stalled while output free");

endmodule

bind memcomparable_key_field_codec_unit mkfc_checker u_mkfc_checker (.*);
